// ===== sv/iptsm_pkg.sv =====
// Shared types and constants for the IPv4 text parse and subnet match unit.
// Used by the top level, its port checker and the testbench; depends on nothing.
package iptsm_pkg;

	localparam int unsigned CHAR_W    = 8;
	localparam int unsigned ADDR_W    = 32;
	localparam int unsigned OCTET_W   = 8;
	localparam int unsigned DONE_W    = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned OUT_DATA_W = 40;

	// Character codes
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
	localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

	// Octet limits
	localparam logic [11:0] OCTET_MAX     = 12'd255;
	localparam logic [1:0]  DIGITS_MAX    = 2'd3;
	localparam logic [1:0]  LAST_OCTET_IX = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NET_ADDR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NET_MASK = 2'd1;

	typedef struct packed {
		logic              in_network;
		logic              host_bits_set;
		logic              format_error;
		logic [ADDR_W-1:0] parsed_address;
	} result_t;

	typedef struct packed {
		logic [OCTET_W-1:0] octet;
		logic [1:0]         digit_cnt;
		logic [1:0]         octet_idx;
		logic [DONE_W-1:0]  done_octets;
		logic               error;
	} parse_state_t;

endpackage

// ===== sv/ipv4_text_parse_subnet_match_unit.sv =====
// IPv4 dotted-decimal parser with subnet match: top level.
// Depends on iptsm_pkg for constants and the result and parse-state types.
//
// Usage
//   Characters arrive on the s_axis channel, one per request: tdata[7:0] is
//   the ASCII character and tlast marks the final character of an address.
//   For every text one result leaves on m_axis when its last character has
//   been parsed; other characters produce nothing on m_axis.
//   The cfg channel writes the network address (index 0) and the subnet mask
//   (index 1); other indexes are ignored. cfg_ready is always high. Write
//   only while no text is in flight.
// Timing
//   A character is registered on acceptance and parsed from that register,
//   and the result of a last character is registered for m_axis. One
//   character is taken per cycle, back to back, unless one with tlast waits
//   on a stalled m_axis. The parse update (octet times ten plus digit,
//   compare to 255) is the one combinational step before the registers.
// Reset and stall
//   arst_n clears the parse state, the configuration registers and both
//   valid flags. While m_axis is stalled the result holds; characters
//   without tlast keep flowing, and a character with tlast waits in the
//   input register, which then holds s_axis_tready low.
module ipv4_text_parse_subnet_match_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// s_axis_tdata: [7:0] text_char
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [iptsm_pkg::CHAR_W-1:0]         s_axis_tdata,
	input  logic                                 s_axis_tlast,
	// m_axis_tdata: [31:0] parsed_address, [32] format_error,
	// [33] host_bits_set, [34] in_network, [39:35] zero
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [iptsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [iptsm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [iptsm_pkg::ADDR_W-1:0]         cfg_data
);

	logic                            valid_s1;
	logic [iptsm_pkg::CHAR_W-1:0]    char_s1;
	logic                            last_s1;

	iptsm_pkg::parse_state_t         state_q;
	iptsm_pkg::parse_state_t         state_next;

	logic [iptsm_pkg::ADDR_W-1:0]    net_addr_q;
	logic [iptsm_pkg::ADDR_W-1:0]    net_mask_q;

	logic                            out_valid_q;
	iptsm_pkg::result_t              out_data_q;
	iptsm_pkg::result_t              result;

	logic                            out_free;
	logic                            consume;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign consume       = valid_s1 && (!last_s1 || out_free);
	assign s_axis_tready = !valid_s1 || consume;
	assign cfg_ready     = 1'b1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// Character parse
	always_comb begin
		logic        is_digit;
		logic [11:0] acc;
		logic        bad;

		is_digit   = (char_s1 >= iptsm_pkg::CHAR_ZERO) && (char_s1 <= iptsm_pkg::CHAR_NINE);
		acc        = {1'b0, state_q.octet, 3'b000} + {3'b000, state_q.octet, 1'b0}
		             + {8'd0, char_s1[3:0]};
		bad        = 1'b0;
		state_next = state_q;

		if (!state_q.error) begin
			if (is_digit) begin
				bad = (state_q.digit_cnt == iptsm_pkg::DIGITS_MAX)
				      || (acc > iptsm_pkg::OCTET_MAX);
				if (!bad) begin
					state_next.octet     = acc[iptsm_pkg::OCTET_W-1:0];
					state_next.digit_cnt = state_q.digit_cnt + 2'd1;
				end
			end else if (char_s1 == iptsm_pkg::CHAR_DOT) begin
				bad = (state_q.digit_cnt == 2'd0)
				      || (state_q.octet_idx == iptsm_pkg::LAST_OCTET_IX);
				if (!bad) begin
					state_next.done_octets = {state_q.done_octets[15:0], state_q.octet};
					state_next.octet_idx   = state_q.octet_idx + 2'd1;
					state_next.octet       = '0;
					state_next.digit_cnt   = 2'd0;
				end
			end else begin
				bad = 1'b1;
			end
			state_next.error = bad;
		end
	end

	// Result of a finished text
	always_comb begin
		logic err;

		err = state_next.error || (state_next.digit_cnt == 2'd0)
		      || (state_next.octet_idx != iptsm_pkg::LAST_OCTET_IX);
		result.format_error   = err;
		result.parsed_address = err ? '0 : {state_next.done_octets, state_next.octet};
		result.host_bits_set  = |(net_addr_q & ~net_mask_q);
		result.in_network     = !err && ((result.parsed_address & net_mask_q)
		                                 == (net_addr_q & net_mask_q));
	end

	// Parse state: clear after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (consume) begin
			state_q <= last_s1 ? '0 : state_next;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= consume && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			out_data_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(iptsm_pkg::OUT_DATA_W - $bits(iptsm_pkg::result_t)){1'b0}},
	                        out_data_q};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_addr_q <= '0;
			net_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				iptsm_pkg::CFG_NET_ADDR: net_addr_q <= cfg_data;
				iptsm_pkg::CFG_NET_MASK: net_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/iptsm_port_checker.sv =====
// Port-level checks for the IPv4 text parse and subnet match unit.
// Depends on iptsm_pkg; bound to ipv4_text_parse_subnet_match_unit below.
module iptsm_port_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [iptsm_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

	// Stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

	// Bad text gives a zero address and no match
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == '0 && !m_axis_tdata[34])
		else $error("format error with address or match set");

	// Pad bits stay zero
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[iptsm_pkg::OUT_DATA_W-1:35] == '0)
		else $error("pad bits of result not zero");

	// No result during reset
	assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("result valid during reset");

endmodule

bind ipv4_text_parse_subnet_match_unit iptsm_port_checker u_iptsm_port_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

// ===== verif/testbench.sv =====
// Self-checking bench for ipv4_text_parse_subnet_match_unit: streams address texts one
// character per request and checks every result against a cycle-free parser model.
// Depends on iptsm_pkg and the unit's RTL only.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [iptsm_pkg::CHAR_W-1:0] char_t;
	typedef logic [iptsm_pkg::ADDR_W-1:0] word_t;

	typedef struct {
		string              text;
		iptsm_pkg::result_t want;
	} directed_row_t;

	localparam int unsigned RES_W           = $bits(iptsm_pkg::result_t);
	localparam int unsigned PHASES          = 10;
	localparam int unsigned CHARS_PER_PHASE = 120;
	localparam int unsigned DRAIN_CYCLES    = 6;
	localparam int unsigned HOLD_OFF_CYCLES = 90;
	localparam int unsigned PRESSURE_PHASE  = 4;
	localparam int unsigned SPARE_PHASE     = 3;

	localparam logic [iptsm_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [iptsm_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
	localparam char_t CHAR_MINUS = 8'h2D;

	localparam iptsm_pkg::result_t BAD_TEXT = '{in_network: 1'b0, host_bits_set: 1'b0,
		format_error: 1'b1, parsed_address: '0};
	localparam iptsm_pkg::result_t ZERO_ADDR = '{in_network: 1'b1, host_bits_set: 1'b0,
		format_error: 1'b0, parsed_address: 32'h0000_0000};
	localparam iptsm_pkg::result_t ONES_ADDR = '{in_network: 1'b1, host_bits_set: 1'b0,
		format_error: 1'b0, parsed_address: 32'hFFFF_FFFF};

	// Registers still hold their reset values while these run.
	directed_row_t directed_rows[5] = '{
		'{"0.0.0.0", ZERO_ADDR},
		'{"255.255.255.255", ONES_ADDR},
		'{"-", BAD_TEXT},
		'{"\377", BAD_TEXT},
		'{".", BAD_TEXT}
	};

	logic                                  clk;
	logic                                  arst_n        = 1'b1;
	logic                                  s_axis_tvalid = 1'b0;
	logic                                  s_axis_tready;
	char_t                                 s_axis_tdata  = '0;
	logic                                  s_axis_tlast  = 1'b0;
	logic                                  m_axis_tvalid;
	logic                                  m_axis_tready = 1'b0;
	logic [iptsm_pkg::OUT_DATA_W-1:0]      m_axis_tdata;
	logic                                  cfg_valid     = 1'b0;
	logic                                  cfg_ready;
	logic [iptsm_pkg::CFG_IDX_W-1:0]       cfg_index     = '0;
	word_t                                 cfg_data      = '0;

	// Parser model state and its copy of the registers
	word_t                         network_reg = '0;
	word_t                         mask_reg    = '0;
	logic [iptsm_pkg::OCTET_W-1:0] octet_acc   = '0;
	logic [1:0]                    digits_seen = '0;
	logic [1:0]                    dots_seen   = '0;
	logic [iptsm_pkg::DONE_W-1:0]  octets_done = '0;
	logic                          text_bad    = 1'b0;

	iptsm_pkg::result_t verdicts_due[$];
	iptsm_pkg::result_t verdicts_pinned[$];
	char_t              text_buf[$];
	int unsigned        mismatches   = 0;
	bit                 idling_on    = 1'b0;
	bit                 hold_off_req = 1'b0;

	ipv4_text_parse_subnet_match_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("ipv4_text_parse_subnet_match_unit regression: fail");
		$finish;
	end

	function automatic void parse_text_char(input char_t ch, input logic last);
		logic [11:0]        acc;
		logic               bad;
		iptsm_pkg::result_t verdict;
		if (!text_bad) begin
			if (ch >= iptsm_pkg::CHAR_ZERO && ch <= iptsm_pkg::CHAR_NINE) begin
				acc = 12'(octet_acc) * 12'd10 + 12'(ch - iptsm_pkg::CHAR_ZERO);
				if (digits_seen == iptsm_pkg::DIGITS_MAX || acc > iptsm_pkg::OCTET_MAX) begin
					text_bad = 1'b1;
				end else begin
					octet_acc   = acc[iptsm_pkg::OCTET_W-1:0];
					digits_seen = digits_seen + 2'd1;
				end
			end else if (ch == iptsm_pkg::CHAR_DOT) begin
				if (digits_seen == 2'd0 || dots_seen == iptsm_pkg::LAST_OCTET_IX) begin
					text_bad = 1'b1;
				end else begin
					octets_done = {octets_done[iptsm_pkg::DONE_W-iptsm_pkg::OCTET_W-1:0],
						octet_acc};
					dots_seen   = dots_seen + 2'd1;
					octet_acc   = '0;
					digits_seen = '0;
				end
			end else begin
				text_bad = 1'b1;
			end
		end
		if (last) begin
			bad = text_bad || digits_seen == 2'd0 || dots_seen != iptsm_pkg::LAST_OCTET_IX;
			verdict.parsed_address = bad ? '0 : {octets_done, octet_acc};
			verdict.format_error   = bad;
			verdict.host_bits_set  = |(network_reg & ~mask_reg);
			verdict.in_network     = !bad &&
				((verdict.parsed_address & mask_reg) == (network_reg & mask_reg));
			// Directed texts carry a hand-written verdict in place of the model's.
			if (verdicts_pinned.size() != 0)
				verdict = verdicts_pinned.pop_front();
			verdicts_due.push_back(verdict);
			octet_acc   = '0;
			digits_seen = '0;
			dots_seen   = '0;
			octets_done = '0;
			text_bad    = 1'b0;
		end
	endfunction

	function automatic void report_field(input string name, input word_t want,
			input word_t got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void check_verdict(input logic [iptsm_pkg::OUT_DATA_W-1:0] data);
		iptsm_pkg::result_t got;
		iptsm_pkg::result_t want;
		got = data[RES_W-1:0];
		if (verdicts_due.size() == 0) begin
			$display("%0t: unexpected result: expected none, actual %h", $time, data);
			mismatches++;
			return;
		end
		want = verdicts_due.pop_front();
		report_field("parsed_address", want.parsed_address, got.parsed_address);
		report_field("format_error", 32'(want.format_error), 32'(got.format_error));
		report_field("host_bits_set", 32'(want.host_bits_set), 32'(got.host_bits_set));
		report_field("in_network", 32'(want.in_network), 32'(got.in_network));
		report_field("pad bits", '0, 32'(data[iptsm_pkg::OUT_DATA_W-1:RES_W]));
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					iptsm_pkg::CFG_NET_ADDR: network_reg = cfg_data;
					iptsm_pkg::CFG_NET_MASK: mask_reg = cfg_data;
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				parse_text_char(s_axis_tdata, s_axis_tlast);
			if (m_axis_tvalid && m_axis_tready)
				check_verdict(m_axis_tdata);
		end
	end

	// Result side: random stalls, plus one long hold-off on request.
	initial begin
		int unsigned hold_left;
		int unsigned stall_left;
		hold_left  = 0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_off_req) begin
				hold_left    = HOLD_OFF_CYCLES;
				hold_off_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9) - 1;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [iptsm_pkg::CFG_IDX_W-1:0] index,
			input word_t value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_char(input char_t ch, input logic last);
		int unsigned gap;
		gap = 0;
		if (idling_on && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 9);
		@(negedge clk);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	task automatic send_text();
		for (int i = 0; i < text_buf.size(); i++)
			send_char(text_buf[i], i == text_buf.size() - 1);
	endtask

	// Drop the request line and wait for every verdict plus pipeline slack.
	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic void push_number(ref char_t q[$], input int unsigned value,
			input int unsigned ndigits);
		int unsigned scale;
		scale = 1;
		repeat (ndigits - 1) scale *= 10;
		for (int i = 0; i < ndigits; i++) begin
			q.push_back(iptsm_pkg::CHAR_ZERO + char_t'((value / scale) % 10));
			scale /= 10;
		end
	endfunction

	// Mostly well-formed addresses, often inside the current network; the
	// rest break one rule each, or are plain noise.
	function automatic void build_text(ref char_t q[$], input word_t net,
			input word_t mask);
		int unsigned kind;
		int unsigned n_oct;
		int unsigned bad_ix;
		int unsigned value;
		word_t       addr;
		char_t       junk;
		q.delete();
		kind = $urandom_range(0, 19);
		addr = $urandom;
		if ($urandom_range(0, 1) == 1)
			addr = (net & mask) | (addr & ~mask);
		if ($urandom_range(0, 9) == 0)
			addr = ($urandom_range(0, 1) == 1) ? '1 : '0;
		if (kind == 19) begin
			repeat ($urandom_range(1, 16)) q.push_back(char_t'($urandom_range(0, 255)));
			return;
		end
		n_oct = 4;
		if (kind == 13)
			n_oct = $urandom_range(1, 3);
		if (kind == 14)
			n_oct = $urandom_range(5, 6);
		bad_ix = $urandom_range(0, n_oct - 1);
		for (int i = 0; i < n_oct; i++) begin
			if (i != 0)
				q.push_back(iptsm_pkg::CHAR_DOT);
			value = $urandom_range(0, 255);
			if (i < 4)
				value = (addr >> (8 * (3 - i))) & 32'hFF;
			if (i == bad_ix && kind == 15)
				push_number(q, $urandom_range(0, 9999), 4);
			else if (i == bad_ix && kind == 16)
				push_number(q, $urandom_range(256, 999), 3);
			else if (!(i == bad_ix && kind == 17))
				push_number(q, value,
					$urandom_range(value >= 100 ? 3 : (value >= 10 ? 2 : 1), 3));
		end
		if (kind == 18) begin
			do junk = char_t'($urandom_range(0, 255));
			while ((junk >= iptsm_pkg::CHAR_ZERO && junk <= iptsm_pkg::CHAR_NINE)
				|| junk == iptsm_pkg::CHAR_DOT);
			if ($urandom_range(0, 3) == 0)
				junk = CHAR_MINUS;
			q.insert($urandom_range(0, q.size()), junk);
		end
	endfunction

	initial begin
		word_t       net;
		word_t       mask;
		int unsigned phase_chars;
		// Assert after time zero so the reset line sees a falling edge.
		#1;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r]) begin
			verdicts_pinned.push_back(directed_rows[r].want);
			text_buf.delete();
			for (int i = 0; i < directed_rows[r].text.len(); i++)
				text_buf.push_back(directed_rows[r].text[i]);
			send_text();
		end
		drain_results();

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					net  = '1;
					mask = '1;
				end
				1: begin
					net  = '1;
					mask = '0;
				end
				2: begin
					net  = '0;
					mask = '1;
				end
				default: begin
					net  = $urandom;
					mask = ~(32'hFFFF_FFFF >> $urandom_range(0, 32));
					if (phase % 2 == 1)
						mask = $urandom;
				end
			endcase
			write_reg(iptsm_pkg::CFG_NET_ADDR, net);
			write_reg(iptsm_pkg::CFG_NET_MASK, mask);
			if (phase == SPARE_PHASE) begin
				write_reg(CFG_SPARE_2, $urandom);
				write_reg(CFG_SPARE_3, $urandom);
			end
			idling_on = phase < PHASES - 2;
			if (phase == PRESSURE_PHASE)
				hold_off_req = 1'b1;
			phase_chars = 0;
			while (phase_chars < CHARS_PER_PHASE) begin
				build_text(text_buf, net, mask);
				send_text();
				phase_chars += text_buf.size();
			end
			drain_results();
		end

		if (verdicts_due.size() != 0) begin
			$display("%0t: %0d verdicts never arrived", $time, verdicts_due.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("ipv4_text_parse_subnet_match_unit regression: pass");
		else
			$display("ipv4_text_parse_subnet_match_unit regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/iptsm_pkg.sv
sv/ipv4_text_parse_subnet_match_unit.sv
sv/iptsm_port_checker.sv
verif/testbench.sv
